>>> src/pwlcs_pkg.sv
// shared types and constants for the piecewise linear curve sampler
`default_nettype none

package pwlcs_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 16;
  // proportion is unsigned Q1.16, saturating at 1.0
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned DIV_CNT_W       = $clog2(FRAC_BITS);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } pwlcs_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } pwlcs_state_e;

  typedef struct packed {
    logic wr;
    logic start;
    logic scan_step;
    logic scan_stop;
    logic mul;
    logic load_out;
  } pwlcs_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic need_div;
    logic div_done;
  } pwlcs_sts_t;

endpackage

`default_nettype wire

>>> src/pwlcs_div.sv
// restoring divider giving the Q0.16 proportion num / den, one bit a cycle
`default_nettype none

module pwlcs_div
  import pwlcs_pkg::*;
#(
  parameter int unsigned W = VALUE_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [W-1:0]         num_i,
  input  wire logic [W-1:0]         den_i,
  output logic      [FRAC_BITS-1:0] quo_o,
  output logic                      done_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [W-1:0]         rem_q;
  logic [W-1:0]         den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [W:0]           shifted;
  logic [W+1:0]         diff;

  // remainder stays below den, so the doubled value fits in W+1 bits
  always_comb begin
    shifted = {rem_q, 1'b0};
    diff    = {1'b0, shifted} - {2'b00, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= diff[W+1] ? shifted[W-1:0] : diff[W-1:0];
      quo_q <= {quo_q[FRAC_BITS-2:0], ~diff[W+1]};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == DIV_CNT_W'(FRAC_BITS - 1));

endmodule

`default_nettype wire

>>> src/pwlcs_ctrl.sv
// sequencer for write and sample requests and the output register handshake
`default_nettype none

module pwlcs_ctrl
  import pwlcs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       opcode_i,
  input  wire logic       out_stall_i,
  input  wire pwlcs_sts_t sts_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output pwlcs_cmd_t      cmd_o
);

  pwlcs_state_e state_q, state_d;
  logic         out_valid_q;
  logic         out_free;
  logic         in_take;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (opcode_i == OP_SAMPLE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.scan_more) begin
          state_d = sts_i.need_div ? ST_DIV : ST_MUL;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.wr        = in_take && (opcode_i == OP_WRITE);
    cmd_o.start     = in_take && (opcode_i == OP_SAMPLE);
    cmd_o.scan_step = (state_q == ST_SCAN) && sts_i.scan_more;
    cmd_o.scan_stop = (state_q == ST_SCAN) && !sts_i.scan_more;
    cmd_o.mul       = (state_q == ST_MUL);
    cmd_o.load_out  = (state_q == ST_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> src/pwlcs_dpath.sv
// point table, scan registers, interpolation arithmetic and result register
`default_nettype none

module pwlcs_dpath
  import pwlcs_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pwlcs_cmd_t                          cmd_i,
  output pwlcs_sts_t                               sts_o,
  input  wire logic                                cfg_valid_i,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]     cfg_data_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       point_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       point_x_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       point_y_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       sample_x_i,
  output logic signed [VALUE_WIDTH-1:0]            y_value_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned VW    = VALUE_WIDTH;
  localparam int unsigned PW    = FRAC_BITS + 1;
  localparam int unsigned MW    = VW + FRAC_BITS + 2;

  // table entries pack y above x
  logic [2*VW-1:0] mem_q [MAX_POINTS];

  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       n_act;
  logic [CNT_W-1:0]       last_full;
  logic [IDX_W-1:0]       last;
  logic [IDX_W-1:0]       idx_q;
  logic [IDX_W-1:0]       rd_addr;
  logic                   rd_en;
  logic                   wr_ok;
  logic [2*VW-1:0]        rd_q;
  logic [2*VW-1:0]        prev_q;
  logic signed [VW-1:0]   sx_q;
  logic signed [VW-1:0]   x_cur, y_cur, x_lo, y_lo;
  logic signed [VW:0]     num, den;
  logic                   need_div;
  logic signed [VW-1:0]   yl_q;
  logic signed [VW:0]     dy_q;
  logic [PW-1:0]          prop_q;
  logic                   div_q;
  logic [PW-1:0]          prop_mul;
  logic signed [MW-1:0]   prod_q;
  logic signed [MW-1:0]   prod_sh;
  logic signed [VW-1:0]   y_q;
  logic [FRAC_BITS-1:0]   quo;
  logic                   div_done;

  // point count of zero acts as one, anything above the table as the table size
  always_comb begin
    if (count_q == '0) begin
      n_act = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_POINTS)) begin
      n_act = CNT_W'(MAX_POINTS);
    end else begin
      n_act = count_q;
    end
    last_full = n_act - 1'b1;
    last      = last_full[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign wr_ok   = ({1'b0, point_index_i} < (IDX_W+1)'(MAX_POINTS));
  assign rd_en   = cmd_i.start || cmd_i.scan_step;
  assign rd_addr = cmd_i.start ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && wr_ok) begin
      mem_q[point_index_i] <= {point_y_i, point_x_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    x_cur = rd_q[VW-1:0];
    y_cur = rd_q[2*VW-1:VW];
    x_lo  = prev_q[VW-1:0];
    y_lo  = prev_q[2*VW-1:VW];
    num   = {sx_q[VW-1], sx_q} - {x_lo[VW-1], x_lo};
    den   = {x_cur[VW-1], x_cur} - {x_lo[VW-1], x_lo};
    // only a proportion strictly inside (0, 1) needs the divider
    need_div = (idx_q != '0) && (den > 0) && (num > 0) && (num < den);
  end

  assign sts_o.scan_more = (idx_q < last) && (x_cur < sx_q);
  assign sts_o.need_div  = need_div;
  assign sts_o.div_done  = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sx_q  <= sample_x_i;
      idx_q <= '0;
    end else if (cmd_i.scan_step) begin
      prev_q <= rd_q;
      idx_q  <= idx_q + 1'b1;
    end
    if (cmd_i.scan_stop) begin
      if (idx_q == '0) begin
        yl_q   <= y_cur;
        dy_q   <= '0;
        prop_q <= '0;
        div_q  <= 1'b0;
      end else begin
        yl_q   <= y_lo;
        dy_q   <= {y_cur[VW-1], y_cur} - {y_lo[VW-1], y_lo};
        prop_q <= ((den <= 0) || (num >= den)) ? {1'b1, {FRAC_BITS{1'b0}}} : '0;
        div_q  <= need_div;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= $signed({1'b0, prop_mul}) * dy_q;
    end
    if (cmd_i.load_out) begin
      y_q <= yl_q + prod_sh[VW-1:0];
    end
  end

  assign prop_mul = div_q ? {1'b0, quo} : prop_q;
  // arithmetic shift floors toward minus infinity
  assign prod_sh  = prod_q >>> FRAC_BITS;

  pwlcs_div #(
    .W (VW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.scan_stop && need_div),
    .num_i   (num[VW-1:0]),
    .den_i   (den[VW-1:0]),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  assign y_value_o = y_q;

endmodule

`default_nettype wire

>>> src/piecewise_linear_curve_sampler.sv
// top level of the piecewise linear curve sampler
//
//   channel  direction  handshake                 payload
//   in       request    in_valid_i / in_stall_o   opcode, point_index, point_x, point_y, sample_x
//   out      result     out_valid_o / out_stall_i y_value
//   cfg      write      cfg_valid_i / cfg_ready_o point_count
//
// a write request is taken while idle; a sample keeps the input stalled from acceptance
// until the next request can be taken: it steps through the points scanned via the
// single table read port, runs the bit-serial divider when the proportion lies
// strictly between 0 and 1, then does one multiply and one add.
// reset leaves the table contents undefined and sets the point count to one.
// a held result only stalls the sequencer once the next result is ready to load.
`default_nettype none

module piecewise_linear_curve_sampler
  import pwlcs_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = MAX_POINTS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0]       point_index_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       point_x_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       point_y_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       sample_x_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]            y_value_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]     cfg_data_i
);

  pwlcs_cmd_t cmd;
  pwlcs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pwlcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  pwlcs_dpath #(
    .MAX_POINTS  (MAX_POINTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .sample_x_i    (sample_x_i),
    .y_value_o     (y_value_o)
  );

  // a sample request keeps the input side busy in the following cycle
  a_sample_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (opcode_i == OP_SAMPLE)) |=> in_stall_o)
    else $error("sample accepted but input not stalled");

  // a write request never produces a result
  a_write_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (opcode_i == OP_WRITE) && !out_valid_o) |=> !out_valid_o)
    else $error("result raised by a write request");

  // a new result only appears at the end of a sample's work
  a_result_from_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while idle");

endmodule

`default_nettype wire
